@@ rtl/sts_pkg.sv @@
package sts_pkg;

    localparam int KEYWORD_CHARS = 8;
    localparam int WORD_W        = 8 * KEYWORD_CHARS;
    // widest position and length over the supported line lengths
    localparam int POS_MAX_W     = 16;
    localparam int LEN_MAX_W     = 17;
    localparam int NUM_KEYWORDS  = 42;
    localparam int NUM_AGGR      = 5;
    localparam int CODE_W        = 6;

    typedef enum logic [3:0] {
        TK_START, TK_EOF, TK_STRING, TK_LPAREN, TK_RPAREN, TK_MATH, TK_COMPARE,
        TK_COMMA, TK_SEMI, TK_DOT, TK_NUMBER, TK_KEYWORD, TK_AGGREGATE, TK_NAME,
        TK_ERROR
    } token_kind_t;

    typedef enum logic [2:0] {
        SM_IDLE, SM_SQUOTE, SM_DQUOTE, SM_NUMBER, SM_WORD, SM_MUTED
    } scan_mode_t;

    typedef enum logic [1:0] {
        ERR_NONE, ERR_UNEXPECTED, ERR_UNTERMINATED
    } error_code_t;

    typedef struct packed {
        token_kind_t           kind;
        logic [7:0]            op;
        logic [POS_MAX_W-1:0]  start;
        logic [LEN_MAX_W-1:0]  len;
        error_code_t           err;
    } token_t;

    // what one input word produces: one or two tokens, the first may be a word
    typedef struct packed {
        token_t              tok0;
        token_t              tok1;
        logic                two;
        logic                is_word;
        logic [WORD_W-1:0]   wbuf;
        logic                special;
    } run_t;

    typedef struct packed {
        token_kind_t        kind;
        logic [CODE_W-1:0]  code;
    } word_match_t;

    localparam logic [WORD_W-1:0] KW_TABLE [NUM_KEYWORDS] = '{
        "SELECT", "UPDATE", "INSERT", "DELETE", "FROM", "SET", "INTO", "WHERE",
        "GROUP", "BY", "HAVING", "ORDER", "ASC", "DESC", "LIMIT", "OFFSET",
        "VALUES", "DEFAULT", "JOIN", "ON", "LEFT", "RIGHT", "INNER", "OUTER",
        "FULL", "CROSS", "CREATE", "RENAME", "DROP", "ALTER", "TABLE",
        "DATABASE", "UNIQUE", "NOT", "IS", "DISTINCT", "AND", "OR", "NULL",
        "FOREIGN", "PRIMARY", "KEY"
    };

    localparam logic [WORD_W-1:0] AGGR_TABLE [NUM_AGGR] = '{
        "AVG", "COUNT", "MAX", "MIN", "SUM"
    };

    // parallel match, tables hold distinct entries so at most one hits
    function automatic word_match_t match_word(input logic [WORD_W-1:0] w,
                                               input logic eligible);
        word_match_t        m;
        logic               kw_hit;
        logic               ag_hit;
        logic [CODE_W-1:0]  kw_code;
        logic [CODE_W-1:0]  ag_code;
        kw_hit  = 1'b0;
        ag_hit  = 1'b0;
        kw_code = '0;
        ag_code = '0;
        for (int i = 0; i < NUM_KEYWORDS; i++) begin
            if (KW_TABLE[i] == w) begin
                kw_hit  = 1'b1;
                kw_code = kw_code | CODE_W'(i);
            end
        end
        for (int i = 0; i < NUM_AGGR; i++) begin
            if (AGGR_TABLE[i] == w) begin
                ag_hit  = 1'b1;
                ag_code = ag_code | CODE_W'(i);
            end
        end
        m.kind = TK_NAME;
        m.code = '0;
        if (eligible && kw_hit) begin
            m.kind = TK_KEYWORD;
            m.code = kw_code;
        end else if (eligible && ag_hit) begin
            m.kind = TK_AGGREGATE;
            m.code = ag_code;
        end
        return m;
    endfunction

endpackage

@@ rtl/sts_front.sv @@
module sts_front #(
    parameter int MAX_LINE = 4096,
    parameter int POS_W    = 12,
    parameter int LEN_W    = 13
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          in_eol,
    input  logic [7:0]    in_char,
    input  logic          q_full,
    output logic          push,
    output sts_pkg::run_t push_data
);
    import sts_pkg::*;

    localparam logic [7:0] CH_STX    = 8'h02;
    localparam logic [7:0] CH_ETX    = 8'h03;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_PIPE   = 8'h7C;

    scan_mode_t         mode_reg, mode_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   start_reg, start_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [WORD_W-1:0]  wbuf_reg, wbuf_next;
    logic               special_reg, special_next;

    logic               accept;
    logic               c_digit, c_letter, c_space, c_wspec;
    logic [7:0]         c_upper;
    logic [LEN_W-1:0]   len_inc;
    logic [WORD_W-1:0]  wa_wbuf;
    logic               closing_quote;

    // fresh scan of the current byte
    logic               f_emit;
    token_t             f_tok;
    scan_mode_t         f_mode;
    logic [POS_W-1:0]   f_start;
    logic [LEN_W-1:0]   f_len;
    logic [WORD_W-1:0]  f_wbuf;
    logic               f_special;

    function automatic token_t make_tok(input token_kind_t kind, input logic [7:0] op,
                                        input logic [POS_W-1:0] start,
                                        input logic [LEN_W-1:0] len,
                                        input error_code_t err);
        token_t t;
        t.kind  = kind;
        t.op    = op;
        t.start = POS_MAX_W'(start);
        t.len   = LEN_MAX_W'(len);
        t.err   = err;
        return t;
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign c_digit  = (in_char >= 8'd48) && (in_char <= 8'd57);
    assign c_letter = ((in_char >= 8'd65) && (in_char <= 8'd90)) ||
                      ((in_char >= 8'd97) && (in_char <= 8'd122));
    assign c_space  = ((in_char >= 8'd9) && (in_char <= 8'd13)) || (in_char == CH_SPACE);
    assign c_wspec  = (in_char == CH_PCT) || (in_char == CH_DOLLAR) || (in_char == CH_COLON);
    assign c_upper  = ((in_char >= 8'd97) && (in_char <= 8'd122)) ? in_char - 8'd32 : in_char;
    assign len_inc  = (len_reg < LEN_W'(MAX_LINE)) ? len_reg + LEN_W'(1) : len_reg;
    assign wa_wbuf  = (len_reg < LEN_W'(KEYWORD_CHARS)) ?
                      {wbuf_reg[WORD_W-9:0], c_upper} : wbuf_reg;
    assign closing_quote = (mode_reg == SM_SQUOTE) ? (in_char == CH_SQUOTE)
                                                   : (in_char == CH_DQUOTE);

    always_comb begin
        f_emit    = 1'b0;
        f_tok     = make_tok(TK_ERROR, 8'd0, pos_reg, LEN_W'(1), ERR_NONE);
        f_mode    = SM_IDLE;
        f_start   = start_reg;
        f_len     = len_reg;
        f_wbuf    = wbuf_reg;
        f_special = special_reg;
        if (!c_space) begin
            unique case (in_char)
                CH_STX: begin
                    f_emit = 1'b1;
                    f_tok  = make_tok(TK_START, 8'd0, pos_reg, '0, ERR_NONE);
                end
                CH_ETX: begin
                    f_emit = 1'b1;
                    f_tok  = make_tok(TK_EOF, 8'd0, pos_reg, '0, ERR_NONE);
                end
                CH_SQUOTE, CH_DQUOTE: begin
                    f_mode  = (in_char == CH_SQUOTE) ? SM_SQUOTE : SM_DQUOTE;
                    f_start = pos_reg;
                    f_len   = '0;
                end
                CH_LPAREN: begin
                    f_emit   = 1'b1;
                    f_tok.kind = TK_LPAREN;
                end
                CH_RPAREN: begin
                    f_emit   = 1'b1;
                    f_tok.kind = TK_RPAREN;
                end
                CH_STAR, CH_PLUS, CH_MINUS: begin
                    f_emit     = 1'b1;
                    f_tok.kind = TK_MATH;
                    f_tok.op   = in_char;
                end
                CH_LT, CH_GT, CH_EQ, CH_SLASH, CH_BANG, CH_AMP, CH_PIPE: begin
                    f_emit     = 1'b1;
                    f_tok.kind = TK_COMPARE;
                    f_tok.op   = in_char;
                end
                CH_COMMA: begin
                    f_emit     = 1'b1;
                    f_tok.kind = TK_COMMA;
                end
                CH_SEMI: begin
                    f_emit     = 1'b1;
                    f_tok.kind = TK_SEMI;
                end
                CH_DOT: begin
                    f_emit     = 1'b1;
                    f_tok.kind = TK_DOT;
                end
                default: begin
                    if (c_digit) begin
                        f_mode  = SM_NUMBER;
                        f_start = pos_reg;
                        f_len   = LEN_W'(1);
                    end else if (c_letter) begin
                        f_mode    = SM_WORD;
                        f_start   = pos_reg;
                        f_len     = LEN_W'(1);
                        f_wbuf    = WORD_W'(c_upper);
                        f_special = 1'b0;
                    end else begin
                        f_emit    = 1'b1;
                        f_tok.err = ERR_UNEXPECTED;
                        f_mode    = SM_MUTED;
                    end
                end
            endcase
        end
    end

    // next state
    always_comb begin
        mode_next    = mode_reg;
        pos_next     = pos_reg;
        start_next   = start_reg;
        len_next     = len_reg;
        wbuf_next    = wbuf_reg;
        special_next = special_reg;
        if (accept) begin
            if (in_eol) begin
                mode_next    = SM_IDLE;
                pos_next     = '0;
                start_next   = '0;
                len_next     = '0;
                wbuf_next    = '0;
                special_next = 1'b0;
            end else begin
                unique case (mode_reg)
                    SM_SQUOTE, SM_DQUOTE: begin
                        if (closing_quote) begin
                            mode_next = SM_IDLE;
                        end else begin
                            len_next = len_inc;
                        end
                    end
                    SM_NUMBER: begin
                        if (c_digit) begin
                            len_next = len_inc;
                        end else begin
                            mode_next    = f_mode;
                            start_next   = f_start;
                            len_next     = f_len;
                            wbuf_next    = f_wbuf;
                            special_next = f_special;
                        end
                    end
                    SM_WORD: begin
                        if (c_letter || c_wspec) begin
                            len_next     = len_inc;
                            wbuf_next    = wa_wbuf;
                            special_next = special_reg | c_wspec;
                        end else begin
                            mode_next    = f_mode;
                            start_next   = f_start;
                            len_next     = f_len;
                            wbuf_next    = f_wbuf;
                            special_next = f_special;
                        end
                    end
                    SM_MUTED: begin
                    end
                    default: begin
                        mode_next    = f_mode;
                        start_next   = f_start;
                        len_next     = f_len;
                        wbuf_next    = f_wbuf;
                        special_next = f_special;
                    end
                endcase
                if (pos_reg < POS_W'(MAX_LINE - 1)) begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    // tokens handed to the queue
    always_comb begin
        push              = 1'b0;
        push_data.tok0    = make_tok(TK_NAME, 8'd0, start_reg, len_reg, ERR_NONE);
        push_data.tok1    = f_tok;
        push_data.two     = 1'b0;
        push_data.is_word = 1'b0;
        push_data.wbuf    = wbuf_reg;
        push_data.special = special_reg;
        if (accept) begin
            if (in_eol) begin
                unique case (mode_reg)
                    SM_SQUOTE, SM_DQUOTE: begin
                        push = 1'b1;
                        push_data.tok0.kind = TK_ERROR;
                        push_data.tok0.err  = ERR_UNTERMINATED;
                    end
                    SM_NUMBER: begin
                        push = 1'b1;
                        push_data.tok0.kind = TK_NUMBER;
                    end
                    SM_WORD: begin
                        push = 1'b1;
                        push_data.is_word = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end else begin
                unique case (mode_reg)
                    SM_SQUOTE, SM_DQUOTE: begin
                        if (closing_quote) begin
                            push = 1'b1;
                            push_data.tok0.kind = TK_STRING;
                        end
                    end
                    SM_NUMBER: begin
                        if (!c_digit) begin
                            push = 1'b1;
                            push_data.tok0.kind = TK_NUMBER;
                            push_data.two       = f_emit;
                        end
                    end
                    SM_WORD: begin
                        if (!(c_letter || c_wspec)) begin
                            push = 1'b1;
                            push_data.is_word = 1'b1;
                            push_data.two     = f_emit;
                        end
                    end
                    SM_MUTED: begin
                    end
                    default: begin
                        push           = f_emit;
                        push_data.tok0 = f_tok;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= SM_IDLE;
            pos_reg     <= '0;
            start_reg   <= '0;
            len_reg     <= '0;
            wbuf_reg    <= '0;
            special_reg <= 1'b0;
        end else begin
            mode_reg    <= mode_next;
            pos_reg     <= pos_next;
            start_reg   <= start_next;
            len_reg     <= len_next;
            wbuf_reg    <= wbuf_next;
            special_reg <= special_next;
        end
    end

    a_muted_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !in_eol && mode_reg == SM_MUTED) |-> !push)
        else $error("token produced on a muted line");

    a_push_needs_word: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (accept && !q_full))
        else $error("queue push without an accepted word");

endmodule

@@ rtl/sts_queue.sv @@
module sts_queue #(
    parameter int DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  sts_pkg::run_t push_data,
    output logic          full,
    input  logic          pop,
    output sts_pkg::run_t head,
    output logic          empty
);
    import sts_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    run_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("run queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("run queue underflow");

endmodule

@@ rtl/sts_back.sv @@
module sts_back #(
    parameter int POS_W = 12,
    parameter int LEN_W = 13
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sts_pkg::run_t                 head,
    input  logic                          empty,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output sts_pkg::token_kind_t          out_kind,
    output logic [sts_pkg::CODE_W-1:0]    out_code,
    output logic [7:0]                    out_op,
    output logic [POS_W-1:0]              out_start,
    output logic [LEN_W-1:0]              out_len,
    output sts_pkg::error_code_t          out_err,
    output logic                          out_last
);
    import sts_pkg::*;

    logic               valid_reg, valid_next;
    token_kind_t        kind_reg, kind_next;
    logic [CODE_W-1:0]  code_reg, code_next;
    logic [7:0]         op_reg, op_next;
    logic [POS_W-1:0]   start_reg, start_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    error_code_t        err_reg, err_next;
    logic               last_reg, last_next;
    logic               pend_valid_reg, pend_valid_next;
    token_t             pend_tok_reg, pend_tok_next;

    logic               load;
    word_match_t        match;

    assign load  = !valid_reg || out_ready;
    assign pop   = load && !pend_valid_reg && !empty;
    assign match = match_word(head.wbuf,
                              !head.special && (head.tok0.len <= LEN_MAX_W'(KEYWORD_CHARS)));

    always_comb begin
        valid_next      = valid_reg;
        kind_next       = kind_reg;
        code_next       = code_reg;
        op_next         = op_reg;
        start_next      = start_reg;
        len_next        = len_reg;
        err_next        = err_reg;
        last_next       = last_reg;
        pend_valid_next = pend_valid_reg;
        pend_tok_next   = pend_tok_reg;
        if (load) begin
            if (pend_valid_reg) begin
                // second token of the run
                valid_next      = 1'b1;
                kind_next       = pend_tok_reg.kind;
                code_next       = '0;
                op_next         = pend_tok_reg.op;
                start_next      = POS_W'(pend_tok_reg.start);
                len_next        = LEN_W'(pend_tok_reg.len);
                err_next        = pend_tok_reg.err;
                last_next       = 1'b1;
                pend_valid_next = 1'b0;
            end else if (!empty) begin
                valid_next      = 1'b1;
                kind_next       = head.is_word ? match.kind : head.tok0.kind;
                code_next       = head.is_word ? match.code : '0;
                op_next         = head.tok0.op;
                start_next      = POS_W'(head.tok0.start);
                len_next        = LEN_W'(head.tok0.len);
                err_next        = head.tok0.err;
                last_next       = !head.two;
                pend_valid_next = head.two;
                pend_tok_next   = head.tok1;
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            valid_reg      <= valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        code_reg     <= code_next;
        op_reg       <= op_next;
        start_reg    <= start_next;
        len_reg      <= len_next;
        err_reg      <= err_next;
        last_reg     <= last_next;
        pend_tok_reg <= pend_tok_next;
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_code  = code_reg;
    assign out_op    = op_reg;
    assign out_start = start_reg;
    assign out_len   = len_reg;
    assign out_err   = err_reg;
    assign out_last  = last_reg;

    a_pend_behind_first: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (valid_reg && !last_reg))
        else $error("second token pending without the first on the output");

    a_first_has_second: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !last_reg) |-> pend_valid_reg)
        else $error("token shown as not last but nothing follows");

endmodule

@@ rtl/sql_token_scanner.sv @@
// SQL token scanner: takes one byte of a line per input word (s_tuser high marks end of
// line) and emits one token per output word, with kind on m_tuser and word code,
// operator byte, start position, length and error code on m_tdata; m_tlast flags the
// last token caused by one input word. A byte is accepted every cycle while the
// four-entry run queue between scanner and emitter has room; a token is registered in
// the run queue and then in the emitter's output register before it is offered, and
// the emitter sends one token per cycle while m_tready is high, so a byte that both
// ends a number or word and is a token by itself yields two output tokens. Sustained
// input rate is one byte per cycle as long as tokens are taken as fast as they are
// made; keywords and aggregate names are resolved by a parallel match in the emitter.
// Positions saturate at MAX_LINE-1 and lengths at MAX_LINE.
module sql_token_scanner #(
    parameter int   MAX_LINE = 4096,
    localparam int  POS_W    = $clog2(MAX_LINE),
    localparam int  LEN_W    = $clog2(MAX_LINE + 1),
    localparam int  DATA_W   = sts_pkg::CODE_W + 8 + POS_W + LEN_W + 2,
    localparam int  TDATA_W  = ((DATA_W + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // char_code
    input  logic                s_tuser,   // mode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata,   // word_code, operator_char, start_pos,
                                           // token_len, error_code, zero fill
    output logic [3:0]          m_tuser,   // token_kind
    output logic                m_tlast
);
    import sts_pkg::*;

    localparam int QUEUE_DEPTH = 4;

    logic               q_full, q_empty, q_push, q_pop;
    run_t               q_in, q_head;
    token_kind_t        out_kind;
    logic [CODE_W-1:0]  out_code;
    logic [7:0]         out_op;
    logic [POS_W-1:0]   out_start;
    logic [LEN_W-1:0]   out_len;
    error_code_t        out_err;

    sts_front #(
        .MAX_LINE (MAX_LINE),
        .POS_W    (POS_W),
        .LEN_W    (LEN_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_eol    (s_tuser),
        .in_char   (s_tdata),
        .q_full    (q_full),
        .push      (q_push),
        .push_data (q_in)
    );

    sts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    sts_back #(
        .POS_W (POS_W),
        .LEN_W (LEN_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (out_kind),
        .out_code  (out_code),
        .out_op    (out_op),
        .out_start (out_start),
        .out_len   (out_len),
        .out_err   (out_err),
        .out_last  (m_tlast)
    );

    assign m_tuser = out_kind;
    assign m_tdata = TDATA_W'({out_err, out_len, out_start, out_op, out_code});

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import sts_pkg::*;

    // predicts the token stream of the scanner and checks what comes out
    class token_scoreboard;
        typedef struct {
            token_kind_t  kind;
            logic [5:0]   code;
            logic [7:0]   op;
            logic [11:0]  start;
            logic [12:0]  len;
            error_code_t  err;
            logic         last;
        } lex_token_t;

        lex_token_t   expected_tokens[$];
        int           errors = 0;
        scan_mode_t   mode = SM_IDLE;
        logic [11:0]  line_pos = '0;
        logic [11:0]  tok_start = '0;
        logic [12:0]  tok_len = '0;
        logic [63:0]  word_buf = '0;
        logic         word_special = 1'b0;

        logic [63:0] keyword_list [42] = '{
            "SELECT", "UPDATE", "INSERT", "DELETE", "FROM", "SET", "INTO", "WHERE",
            "GROUP", "BY", "HAVING", "ORDER", "ASC", "DESC", "LIMIT", "OFFSET",
            "VALUES", "DEFAULT", "JOIN", "ON", "LEFT", "RIGHT", "INNER", "OUTER",
            "FULL", "CROSS", "CREATE", "RENAME", "DROP", "ALTER", "TABLE",
            "DATABASE", "UNIQUE", "NOT", "IS", "DISTINCT", "AND", "OR", "NULL",
            "FOREIGN", "PRIMARY", "KEY"
        };
        logic [63:0] aggregate_list [5] = '{"AVG", "COUNT", "MAX", "MIN", "SUM"};

        function void clear_line();
            mode         = SM_IDLE;
            line_pos     = '0;
            tok_start    = '0;
            tok_len      = '0;
            word_buf     = '0;
            word_special = 1'b0;
        endfunction

        function logic [12:0] bump_len(logic [12:0] v);
            return (v < 13'd4096) ? v + 13'd1 : v;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= 8'd48 && c <= 8'd57;
        endfunction

        function bit is_special(logic [7:0] c);
            return c == "%" || c == "$" || c == ":";
        endfunction

        function void add_token(token_kind_t kind, logic [5:0] code, logic [7:0] op,
                                logic [11:0] start, logic [12:0] len, error_code_t err);
            lex_token_t t;
            t = '{kind, code, op, start, len, err, 1'b0};
            expected_tokens.insert(expected_tokens.size(), t);
        endfunction

        function void add_word_char(logic [7:0] c);
            if (is_special(c))
                word_special = 1'b1;
            if (tok_len < 13'd8) begin
                if (c >= 8'd97 && c <= 8'd122)
                    c = c - 8'd32;
                word_buf = {word_buf[55:0], c};
            end
            tok_len = bump_len(tok_len);
        endfunction

        function void finish_word();
            token_kind_t kind;
            logic [5:0]  code;
            kind = TK_NAME;
            code = '0;
            if (!word_special && tok_len <= 13'd8) begin
                for (int i = 0; i < 42; i++) begin
                    if (kind == TK_NAME && keyword_list[i] == word_buf) begin
                        kind = TK_KEYWORD;
                        code = 6'(i);
                    end
                end
                for (int i = 0; i < 5; i++) begin
                    if (kind == TK_NAME && aggregate_list[i] == word_buf) begin
                        kind = TK_AGGREGATE;
                        code = 6'(i);
                    end
                end
            end
            add_token(kind, code, 8'd0, tok_start, tok_len, ERR_NONE);
        endfunction

        // byte seen between tokens, or right after the token it ended
        function void scan_byte(logic [7:0] c);
            if ((c >= 8'd9 && c <= 8'd13) || c == 8'd32)
                return;
            case (c)
                8'd2: add_token(TK_START, '0, 8'd0, line_pos, 13'd0, ERR_NONE);
                8'd3: add_token(TK_EOF, '0, 8'd0, line_pos, 13'd0, ERR_NONE);
                8'd39, 8'd34: begin
                    mode      = (c == 8'd39) ? SM_SQUOTE : SM_DQUOTE;
                    tok_start = line_pos;
                    tok_len   = '0;
                end
                "(": add_token(TK_LPAREN, '0, 8'd0, line_pos, 13'd1, ERR_NONE);
                ")": add_token(TK_RPAREN, '0, 8'd0, line_pos, 13'd1, ERR_NONE);
                "*", "+", "-": add_token(TK_MATH, '0, c, line_pos, 13'd1, ERR_NONE);
                "<", ">", "=", "/", "!", "&", "|":
                    add_token(TK_COMPARE, '0, c, line_pos, 13'd1, ERR_NONE);
                ",": add_token(TK_COMMA, '0, 8'd0, line_pos, 13'd1, ERR_NONE);
                ";": add_token(TK_SEMI, '0, 8'd0, line_pos, 13'd1, ERR_NONE);
                ".": add_token(TK_DOT, '0, 8'd0, line_pos, 13'd1, ERR_NONE);
                default: begin
                    if (is_digit(c)) begin
                        mode      = SM_NUMBER;
                        tok_start = line_pos;
                        tok_len   = 13'd1;
                    end else if (is_letter(c)) begin
                        mode         = SM_WORD;
                        tok_start    = line_pos;
                        tok_len      = '0;
                        word_buf     = '0;
                        word_special = 1'b0;
                        add_word_char(c);
                    end else begin
                        add_token(TK_ERROR, '0, 8'd0, line_pos, 13'd1, ERR_UNEXPECTED);
                        mode = SM_MUTED;
                    end
                end
            endcase
        endfunction

        function void note_word(bit eol, logic [7:0] c);
            int n_before;
            n_before = expected_tokens.size();
            if (eol) begin
                case (mode)
                    SM_SQUOTE, SM_DQUOTE:
                        add_token(TK_ERROR, '0, 8'd0, tok_start, tok_len, ERR_UNTERMINATED);
                    SM_NUMBER: add_token(TK_NUMBER, '0, 8'd0, tok_start, tok_len, ERR_NONE);
                    SM_WORD: finish_word();
                    default: ;
                endcase
                clear_line();
            end else begin
                case (mode)
                    SM_SQUOTE, SM_DQUOTE: begin
                        if (c == ((mode == SM_SQUOTE) ? 8'd39 : 8'd34)) begin
                            add_token(TK_STRING, '0, 8'd0, tok_start, tok_len, ERR_NONE);
                            mode = SM_IDLE;
                        end else begin
                            tok_len = bump_len(tok_len);
                        end
                    end
                    SM_NUMBER: begin
                        if (is_digit(c)) begin
                            tok_len = bump_len(tok_len);
                        end else begin
                            add_token(TK_NUMBER, '0, 8'd0, tok_start, tok_len, ERR_NONE);
                            mode = SM_IDLE;
                            scan_byte(c);
                        end
                    end
                    SM_WORD: begin
                        if (is_letter(c) || is_special(c)) begin
                            add_word_char(c);
                        end else begin
                            finish_word();
                            mode = SM_IDLE;
                            scan_byte(c);
                        end
                    end
                    SM_MUTED: ;
                    default: scan_byte(c);
                endcase
                if (line_pos < 12'd4095)
                    line_pos = line_pos + 12'd1;
            end
            if (expected_tokens.size() > n_before)
                expected_tokens[expected_tokens.size() - 1].last = 1'b1;
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] token mismatch: %s", $time, what);
        endtask

        task check_token(logic [3:0] kind_bits, logic [47:0] data, logic last);
            lex_token_t t;
            if (expected_tokens.size() == 0) begin
                report($sformatf("extra token kind %0d start %0d", kind_bits, data[25:14]));
                return;
            end
            t = expected_tokens.pop_front();
            if (kind_bits !== t.kind)
                report($sformatf("kind %0d, want %0d (start %0d)", kind_bits, t.kind, t.start));
            if (data[5:0] !== t.code)
                report($sformatf("code %0d, want %0d (start %0d)", data[5:0], t.code, t.start));
            if (data[13:6] !== t.op)
                report($sformatf("op %0h, want %0h (start %0d)", data[13:6], t.op, t.start));
            if (data[25:14] !== t.start)
                report($sformatf("start %0d, want %0d", data[25:14], t.start));
            if (data[38:26] !== t.len)
                report($sformatf("len %0d, want %0d (start %0d)", data[38:26], t.len, t.start));
            if (data[40:39] !== t.err)
                report($sformatf("err %0d, want %0d (start %0d)", data[40:39], t.err, t.start));
            if (data[47:41] !== 7'd0)
                report($sformatf("fill bits %0h not zero (start %0d)", data[47:41], t.start));
            if (last !== t.last)
                report($sformatf("tlast %0b, want %0b (start %0d)", last, t.last, t.start));
        endtask
    endclass

    logic         aclk;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'd0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [47:0]  m_tdata;
    logic [3:0]   m_tuser;
    logic         m_tlast;

    token_scoreboard tokens_sb = new();
    int  items_sent = 0;
    bit  source_idle = 1'b1;
    bit  sink_idle = 1'b1;
    bit  hold_request = 1'b0;

    sql_token_scanner i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic send_word(bit eol, logic [7:0] c);
        while (source_idle && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= eol;
        do @(posedge aclk); while (!s_tready);
        tokens_sb.note_word(eol, c);
        items_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_word(1'b0, s[i]);
    endtask

    task automatic send_eol();
        send_word(1'b1, 8'($urandom_range(255)));
    endtask

    // table words are upper case, flip letters to lower case at random
    task automatic send_table_word(logic [63:0] w);
        logic [7:0] ch;
        for (int i = 7; i >= 0; i--) begin
            ch = w[i*8 +: 8];
            if (ch != 8'd0) begin
                if ($urandom_range(1))
                    ch = ch | 8'h20;
                send_word(1'b0, ch);
            end
        end
    endtask

    task automatic send_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            send_word(1'b0, 8'd32);
        else if (r < 75)
            send_word(1'b0, 8'($urandom_range(9, 13)));
    endtask

    task automatic random_line();
        string       ops;
        string       specials;
        int          count;
        int          pick;
        int          n;
        logic [7:0]  ch;
        logic [7:0]  quote;
        ops      = "()*+-<>=/!&|,;.";
        specials = "%$:";
        count    = $urandom_range(1, 10);
        for (int t = 0; t < count; t++) begin
            pick = $urandom_range(99);
            if (pick < 18) begin
                send_table_word(tokens_sb.keyword_list[$urandom_range(41)]);
            end else if (pick < 26) begin
                send_table_word(tokens_sb.aggregate_list[$urandom_range(4)]);
            end else if (pick < 40) begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++) begin
                    if (i > 0 && $urandom_range(9) == 0)
                        ch = specials[$urandom_range(2)];
                    else
                        ch = ($urandom_range(1) ? 8'd97 : 8'd65) + 8'($urandom_range(25));
                    send_word(1'b0, ch);
                end
            end else if (pick < 52) begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_word(1'b0, 8'd48 + 8'($urandom_range(9)));
            end else if (pick < 64) begin
                quote = $urandom_range(1) ? 8'd39 : 8'd34;
                send_word(1'b0, quote);
                n = $urandom_range(0, 8);
                for (int i = 0; i < n; i++) begin
                    ch = 8'($urandom_range(32, 126));
                    if (ch == quote)
                        ch = "x";
                    send_word(1'b0, ch);
                end
                // leave the string open, the end of line closes it with an error
                if ($urandom_range(9) == 0)
                    break;
                send_word(1'b0, quote);
            end else if (pick < 90) begin
                send_word(1'b0, ops[$urandom_range(ops.len() - 1)]);
            end else if (pick < 95) begin
                send_word(1'b0, $urandom_range(1) ? 8'd2 : 8'd3);
            end else begin
                send_word(1'b0, 8'($urandom_range(255)));
            end
            send_gap();
        end
        send_eol();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        send_word(1'b0, 8'd2);
        send_text("sUm(0)<=a$b;");
        send_eol();
        send_text("\"ab");
        send_eol();
        send_text("#x");
        send_eol();
        send_eol();
        send_text("Database1");
        send_eol();

        while (items_sent < 300)
            random_line();

        // no idling, and the sink stops long enough for the input to back up
        source_idle  = 1'b0;
        sink_idle    = 1'b0;
        hold_request = 1'b1;
        while (items_sent < 450)
            random_line();
        source_idle = 1'b1;
        sink_idle   = 1'b1;

        while (items_sent < 700)
            random_line();
        s_tvalid <= 1'b0;

        while (tokens_sb.expected_tokens.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (tokens_sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_request = 1'b0;
            end else begin
                m_tready <= !sink_idle || ($urandom_range(99) >= 35);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tokens_sb.check_token(m_tuser, m_tdata, m_tlast);
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < 3000) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

endmodule
